// ----- src/mhtq_pkg.sv -----
// Package for the min-heap timer queue: operation and status codes, the
// memory command struct and shared constants. No dependencies.
package mhtq_pkg;

	localparam int HANDLE_W     = 6;
	localparam int NUM_HANDLES  = 2 ** HANDLE_W;
	localparam int IN_TIME_W    = 32;
	localparam int MAX_OUT      = 64;
	localparam int CNT_W        = $clog2(MAX_OUT + 1);
	localparam int CAPACITY_DEF = 64;
	localparam int TIME_W_DEF   = 32;

	typedef enum logic [1:0] {
		FN_ADD  = 2'd0,
		FN_DEL  = 2'd1,
		FN_ADJ  = 2'd2,
		FN_TICK = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_ABSENT = 2'd2,
		ST_DUP    = 2'd3
	} status_t;

	// Heap storage command, broadcast to every level cell.
	typedef struct packed {
		logic rd;
		logic wr;
	} cmd_t;

endpackage

// ----- src/mhtq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mhtq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/mhtq_level.sv -----
// One heap level cell: holds every entry of one level of the heap, stored as
// sibling pairs, and passes read data along the level chain.
// Depends on mhtq_pkg and mhtq_ram.
module mhtq_level #(
	parameter int LEVEL = 0,
	parameter int IW    = 7,
	parameter int EW    = 38
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mhtq_pkg::cmd_t    cmd,
	input  logic [IW-1:0]     rd_idx,
	input  logic [IW-1:0]     wr_idx,
	input  logic [EW-1:0]     wr_entry,
	input  logic [2*EW-1:0]   chain_in,
	output logic [2*EW-1:0]   chain_out
);

	logic            rd_hit;
	logic            wr_hit;
	logic            sel_q;
	logic [2*EW-1:0] pair;

	// 1-based heap index idx lives on this level when idx >> LEVEL is one.
	assign rd_hit = (rd_idx >> LEVEL) == IW'(1);
	assign wr_hit = (wr_idx >> LEVEL) == IW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
		end else if (cmd.rd) begin
			sel_q <= rd_hit;
		end
	end

	// Take over the chain when the last read hit this level.
	assign chain_out = sel_q ? pair : chain_in;

	generate
		if (LEVEL == 0) begin : g_root
			logic [EW-1:0] root_q;

			always_ff @(posedge clk) begin
				if (cmd.wr && wr_hit) begin
					root_q <= wr_entry;
				end
			end

			// Root shows on both slots of the pair.
			assign pair = {root_q, root_q};
		end else if (LEVEL == 1) begin : g_pair
			logic [EW-1:0] slot0_q;
			logic [EW-1:0] slot1_q;

			always_ff @(posedge clk) begin
				if (cmd.wr && wr_hit && !wr_idx[0]) begin
					slot0_q <= wr_entry;
				end
				if (cmd.wr && wr_hit && wr_idx[0]) begin
					slot1_q <= wr_entry;
				end
			end

			assign pair = {slot1_q, slot0_q};
		end else begin : g_mem
			localparam int ROWS = 2 ** (LEVEL - 1);

			logic [EW-1:0] rd0;
			logic [EW-1:0] rd1;

			mhtq_ram #(.WIDTH(EW), .DEPTH(ROWS)) u_even (
				.clk   (clk),
				.we    (cmd.wr && wr_hit && !wr_idx[0]),
				.waddr (wr_idx[LEVEL-1:1]),
				.wdata (wr_entry),
				.re    (cmd.rd && rd_hit),
				.raddr (rd_idx[LEVEL-1:1]),
				.rdata (rd0)
			);

			mhtq_ram #(.WIDTH(EW), .DEPTH(ROWS)) u_odd (
				.clk   (clk),
				.we    (cmd.wr && wr_hit && wr_idx[0]),
				.waddr (wr_idx[LEVEL-1:1]),
				.wdata (wr_entry),
				.re    (cmd.rd && rd_hit),
				.raddr (rd_idx[LEVEL-1:1]),
				.rdata (rd1)
			);

			assign pair = {rd1, rd0};
		end
	endgenerate

endmodule

// ----- src/min_heap_timer_queue.sv -----
// Top level of the min-heap timer queue: operation sequencer, handle table
// and the chain of heap level cells. Depends on mhtq_pkg, mhtq_level, mhtq_ram.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------------------
//   command  | start / busy, taken when  | func, handle, expire_time, current_time
//            | start is high, busy low   |
//   result   | valid, one-cycle strobe   | result_handle, expired, status, last
//
// Steps: a rejected add, delete or adjust ends after the decide state. A good
// operation then climbs or sinks the entry, one heap level per step. A tick
// pops each due root in turn, refilling the root from the last entry and
// sinking it level by level. Each level step is one registered read through
// the level chain and one compare and write. Reset clears the sequencer state,
// its flags, the present bits and the occupancy only; the heap levels and the
// handle table are never cleared and are read only where written, so the
// block takes commands right after reset. Results cannot be stalled: each one
// is shown for exactly one cycle while the next command may already be taken.
module min_heap_timer_queue #(
	parameter int CAPACITY   = mhtq_pkg::CAPACITY_DEF,
	parameter int TIME_WIDTH = mhtq_pkg::TIME_W_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       func,
	input  logic [mhtq_pkg::HANDLE_W-1:0]    handle,
	input  logic [mhtq_pkg::IN_TIME_W-1:0]   expire_time,
	input  logic [mhtq_pkg::IN_TIME_W-1:0]   current_time,
	output logic                             valid,
	output logic [mhtq_pkg::HANDLE_W-1:0]    result_handle,
	output logic                             expired,
	output logic [1:0]                       status,
	output logic                             last
);

	// Heap index is 1-based: root is 1, children of i are 2i and 2i+1.
	localparam int IW = $clog2(CAPACITY + 1);
	localparam int NL = IW;
	localparam int HW = mhtq_pkg::HANDLE_W;
	localparam int EW = HW + TIME_WIDTH;
	localparam int CW = mhtq_pkg::CNT_W;

	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_DECIDE = 10'b00_0000_0010,
		S_LAST   = 10'b00_0000_0100,
		S_UP_RD  = 10'b00_0000_1000,
		S_UP_CMP = 10'b00_0001_0000,
		S_DN_RD  = 10'b00_0010_0000,
		S_DN_CMP = 10'b00_0100_0000,
		S_PLACE  = 10'b00_1000_0000,
		S_TCMP   = 10'b01_0000_0000,
		S_TNEXT  = 10'b10_0000_0000
	} state_t;

	state_t                      st_q, st_d;
	mhtq_pkg::func_t             op_q, op_d;
	logic [HW-1:0]               ohnd_q, ohnd_d;   // handle of the command
	logic [HW-1:0]               ch_q, ch_d;       // carried entry: handle
	logic [TIME_WIDTH-1:0]       ck_q, ck_d;       // carried entry: key
	logic [TIME_WIDTH-1:0]       now_q, now_d;
	logic [IW-1:0]               idx_q, idx_d;
	logic [IW-1:0]               occ_q, occ_d;
	logic [CW-1:0]               cnt_q, cnt_d;
	logic [HW-1:0]               pend_q, pend_d;
	logic                        pendv_q, pendv_d;
	logic                        sink_q, sink_d;
	logic                        rslot_q, rslot_d;
	logic                        two_q, two_d;
	logic [mhtq_pkg::NUM_HANDLES-1:0] present_q, present_d;

	logic                        valid_q, vld_d;
	logic [HW-1:0]               rh_q, rh_d;
	logic                        ex_q, ex_d;
	mhtq_pkg::status_t           so_q, so_d;
	logic                        la_q, la_d;

	mhtq_pkg::cmd_t              cmd;
	logic [IW-1:0]               rd_idx;
	logic [IW-1:0]               wr_idx;
	logic [EW-1:0]               wr_entry;

	logic                        pos_re;
	logic                        pos_we;
	logic [HW-1:0]               pos_raddr;
	logic [HW-1:0]               pos_waddr;
	logic [IW-1:0]               pos_wdata;
	logic [IW-1:0]               pos_rdata;

	logic [2*EW-1:0]             chain [NL+1];
	logic [EW-1:0]               ent_lo;
	logic [EW-1:0]               ent_hi;
	logic [EW-1:0]               sel_ent;
	logic [HW-1:0]               sel_h;
	logic [TIME_WIDTH-1:0]       sel_k;
	logic                        pick_hi;
	logic [EW-1:0]               pick_ent;
	logic [IW-1:0]               pick_idx;
	logic [IW-1:0]               par_idx;
	logic [IW:0]                 c_full;
	logic [IW:0]                 occ_ext;
	logic [TIME_WIDTH-1:0]       key_in;
	logic [TIME_WIDTH-1:0]       now_in;

	// Times are kept to TIME_WIDTH bits.
	assign key_in = TIME_WIDTH'(expire_time);
	assign now_in = TIME_WIDTH'(current_time);

	// ------------------------------------------------------------------
	// Heap level chain: level 0 first, the selected level drives the end.
	// ------------------------------------------------------------------
	assign chain[0] = '0;

	generate
		for (genvar g = 0; g < NL; g++) begin : g_lvl
			mhtq_level #(.LEVEL(g), .IW(IW), .EW(EW)) u_level (
				.clk       (clk),
				.arst_n    (arst_n),
				.cmd       (cmd),
				.rd_idx    (rd_idx),
				.wr_idx    (wr_idx),
				.wr_entry  (wr_entry),
				.chain_in  (chain[g]),
				.chain_out (chain[g+1])
			);
		end
	endgenerate

	// Handle to heap index table.
	mhtq_ram #(.WIDTH(IW), .DEPTH(mhtq_pkg::NUM_HANDLES)) u_pos (
		.clk   (clk),
		.we    (pos_we),
		.waddr (pos_waddr),
		.wdata (pos_wdata),
		.re    (pos_re),
		.raddr (pos_raddr),
		.rdata (pos_rdata)
	);

	// Read data of the last heap read: a sibling pair, or one entry by slot.
	assign ent_lo  = chain[NL][EW-1:0];
	assign ent_hi  = chain[NL][2*EW-1:EW];
	assign sel_ent = rslot_q ? ent_hi : ent_lo;
	assign sel_h   = sel_ent[EW-1:TIME_WIDTH];
	assign sel_k   = sel_ent[TIME_WIDTH-1:0];

	// Smaller child; the right one only wins on a strictly smaller key.
	assign pick_hi  = two_q && (ent_lo[TIME_WIDTH-1:0] > ent_hi[TIME_WIDTH-1:0]);
	assign pick_ent = pick_hi ? ent_hi : ent_lo;
	assign pick_idx = {idx_q[IW-2:0], pick_hi};

	assign par_idx = idx_q >> 1;
	assign c_full  = {idx_q, 1'b0};
	assign occ_ext = {1'b0, occ_q};

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_comb begin
		st_d      = st_q;
		op_d      = op_q;
		ohnd_d    = ohnd_q;
		ch_d      = ch_q;
		ck_d      = ck_q;
		now_d     = now_q;
		idx_d     = idx_q;
		occ_d     = occ_q;
		cnt_d     = cnt_q;
		pend_d    = pend_q;
		pendv_d   = pendv_q;
		sink_d    = sink_q;
		rslot_d   = rslot_q;
		two_d     = two_q;
		present_d = present_q;

		cmd       = '0;
		rd_idx    = idx_q;
		wr_idx    = idx_q;
		wr_entry  = {ch_q, ck_q};
		pos_re    = 1'b0;
		pos_raddr = handle;
		pos_we    = 1'b0;
		pos_waddr = ch_q;
		pos_wdata = idx_q;

		vld_d = 1'b0;
		rh_d  = ohnd_q;
		ex_d  = 1'b0;
		so_d  = mhtq_pkg::ST_OK;
		la_d  = 1'b1;

		unique case (st_q)
			S_IDLE: begin
				if (start) begin
					op_d    = mhtq_pkg::func_t'(func);
					ohnd_d  = handle;
					ch_d    = handle;
					ck_d    = key_in;
					now_d   = now_in;
					cnt_d   = '0;
					pendv_d = 1'b0;
					pos_re  = 1'b1;
					if (mhtq_pkg::func_t'(func) == mhtq_pkg::FN_TICK) begin
						// Nothing queued: the tick ends here without a result.
						if (occ_q != '0) begin
							cmd.rd  = 1'b1;
							rd_idx  = IW'(1);
							rslot_d = 1'b1;
							st_d    = S_TCMP;
						end
					end else begin
						st_d = S_DECIDE;
					end
				end
			end

			S_DECIDE: begin
				if (op_q == mhtq_pkg::FN_ADD) begin
					if (present_q[ohnd_q]) begin
						vld_d = 1'b1;
						so_d  = mhtq_pkg::ST_DUP;
						st_d  = S_IDLE;
					end else if (occ_q == IW'(CAPACITY)) begin
						vld_d = 1'b1;
						so_d  = mhtq_pkg::ST_FULL;
						st_d  = S_IDLE;
					end else begin
						// Append at the end and climb.
						idx_d              = occ_q + IW'(1);
						occ_d              = occ_q + IW'(1);
						present_d[ohnd_q]  = 1'b1;
						sink_d             = 1'b0;
						st_d               = (occ_q == '0) ? S_PLACE : S_UP_RD;
					end
				end else if (!present_q[ohnd_q] || pos_rdata > occ_q) begin
					vld_d = 1'b1;
					so_d  = mhtq_pkg::ST_ABSENT;
					st_d  = S_IDLE;
				end else if (op_q == mhtq_pkg::FN_ADJ) begin
					idx_d  = pos_rdata;
					sink_d = 1'b1;
					st_d   = (pos_rdata == IW'(1)) ? S_DN_RD : S_UP_RD;
				end else begin
					// Delete: drop the handle, refill its slot from the last entry.
					present_d[ohnd_q] = 1'b0;
					occ_d             = occ_q - IW'(1);
					if (pos_rdata == occ_q) begin
						vld_d = 1'b1;
						st_d  = S_IDLE;
					end else begin
						idx_d   = pos_rdata;
						cmd.rd  = 1'b1;
						rd_idx  = occ_q;
						rslot_d = occ_q[0];
						sink_d  = 1'b1;
						st_d    = S_LAST;
					end
				end
			end

			S_LAST: begin
				ch_d = sel_h;
				ck_d = sel_k;
				st_d = (idx_q == IW'(1)) ? S_DN_RD : S_UP_RD;
			end

			S_UP_RD: begin
				cmd.rd  = 1'b1;
				rd_idx  = par_idx;
				rslot_d = par_idx[0];
				st_d    = S_UP_CMP;
			end

			S_UP_CMP: begin
				if (sel_k > ck_q) begin
					// Pull the parent down into the hole and climb.
					cmd.wr    = 1'b1;
					wr_entry  = sel_ent;
					pos_we    = 1'b1;
					pos_waddr = sel_h;
					idx_d     = par_idx;
					if (par_idx != IW'(1)) begin
						st_d = S_UP_RD;
					end else begin
						st_d = sink_q ? S_DN_RD : S_PLACE;
					end
				end else begin
					st_d = sink_q ? S_DN_RD : S_PLACE;
				end
			end

			S_DN_RD: begin
				if (c_full <= occ_ext) begin
					cmd.rd = 1'b1;
					rd_idx = c_full[IW-1:0];
					two_d  = c_full < occ_ext;
					st_d   = S_DN_CMP;
				end else begin
					st_d = S_PLACE;
				end
			end

			S_DN_CMP: begin
				if (ck_q > pick_ent[TIME_WIDTH-1:0]) begin
					// Lift the smaller child into the hole and sink.
					cmd.wr    = 1'b1;
					wr_entry  = pick_ent;
					pos_we    = 1'b1;
					pos_waddr = pick_ent[EW-1:TIME_WIDTH];
					idx_d     = pick_idx;
					st_d      = S_DN_RD;
				end else begin
					st_d = S_PLACE;
				end
			end

			S_PLACE: begin
				cmd.wr = 1'b1;
				pos_we = 1'b1;
				if (op_q == mhtq_pkg::FN_TICK) begin
					st_d = S_TNEXT;
				end else begin
					vld_d = 1'b1;
					st_d  = S_IDLE;
				end
			end

			S_TCMP: begin
				if (sel_k <= now_q && cnt_q < CW'(mhtq_pkg::MAX_OUT)) begin
					// Root is due: release the held result, hold this one.
					if (pendv_q) begin
						vld_d = 1'b1;
						rh_d  = pend_q;
						ex_d  = 1'b1;
						la_d  = 1'b0;
					end
					pend_d           = sel_h;
					pendv_d          = 1'b1;
					cnt_d            = cnt_q + CW'(1);
					present_d[sel_h] = 1'b0;
					occ_d            = occ_q - IW'(1);
					if (occ_q == IW'(1)) begin
						st_d = S_TNEXT;
					end else begin
						idx_d   = IW'(1);
						cmd.rd  = 1'b1;
						rd_idx  = occ_q;
						rslot_d = occ_q[0];
						sink_d  = 1'b1;
						st_d    = S_LAST;
					end
				end else begin
					if (pendv_q) begin
						vld_d = 1'b1;
						rh_d  = pend_q;
						ex_d  = 1'b1;
					end
					pendv_d = 1'b0;
					st_d    = S_IDLE;
				end
			end

			S_TNEXT: begin
				if (occ_q != '0) begin
					cmd.rd  = 1'b1;
					rd_idx  = IW'(1);
					rslot_d = 1'b1;
					st_d    = S_TCMP;
				end else begin
					vld_d   = 1'b1;
					rh_d    = pend_q;
					ex_d    = 1'b1;
					pendv_d = 1'b0;
					st_d    = S_IDLE;
				end
			end

			default: begin
				st_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			occ_q     <= '0;
			present_q <= '0;
			pendv_q   <= 1'b0;
			valid_q   <= 1'b0;
		end else begin
			st_q      <= st_d;
			occ_q     <= occ_d;
			present_q <= present_d;
			pendv_q   <= pendv_d;
			valid_q   <= vld_d;
		end
	end

	// Working and result payload: no reset needed.
	always_ff @(posedge clk) begin
		op_q    <= op_d;
		ohnd_q  <= ohnd_d;
		ch_q    <= ch_d;
		ck_q    <= ck_d;
		now_q   <= now_d;
		idx_q   <= idx_d;
		cnt_q   <= cnt_d;
		pend_q  <= pend_d;
		sink_q  <= sink_d;
		rslot_q <= rslot_d;
		two_q   <= two_d;
		rh_q    <= rh_d;
		ex_q    <= ex_d;
		so_q    <= so_d;
		la_q    <= la_d;
	end

	assign busy          = (st_q != S_IDLE);
	assign valid         = valid_q;
	assign result_handle = rh_q;
	assign expired       = ex_q;
	assign status        = so_q;
	assign last          = la_q;

`ifndef SYNTHESIS
	// Every present handle has a heap slot once an operation has finished.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_IDLE) |-> ($countones(present_q) == occ_q))
		else $error("present count differs from occupancy");

	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= IW'(CAPACITY))
		else $error("occupancy above capacity");

	// Heap reads and writes never share a cycle.
	a_rw: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.rd && cmd.wr))
		else $error("heap read and write in one cycle");

	// Only tick results can be followed by more results of the same item.
	a_more: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !la_q) |-> (ex_q && busy))
		else $error("non-final result outside a tick");

	// A held tick result is always released before the block goes idle.
	a_pend: assert property (@(posedge clk) disable iff (!arst_n)
		pendv_q |-> busy)
		else $error("held tick result while idle");
`endif

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking bench for min_heap_timer_queue. It drives add, delete, adjust and
// tick items and checks every result against a shadow heap kept in the bench.
// Depends on mhtq_pkg and min_heap_timer_queue.
module testbench;

	localparam int CAP          = 64;
	localparam int HW           = mhtq_pkg::HANDLE_W;
	localparam int NH           = mhtq_pkg::NUM_HANDLES;
	localparam int LIMIT        = 4_000_000;
	localparam int DRAIN_CYCLES = 200;

	// One expected result item.
	typedef struct packed {
		logic [HW-1:0]     hnd;
		logic              fired;
		mhtq_pkg::status_t st;
		logic              lst;
	} timer_result_t;

	logic          clk = 1'b0;
	logic          arst_n;
	logic          start;
	logic          busy;
	logic [1:0]    func;
	logic [HW-1:0] handle;
	logic [31:0]   expire_time;
	logic [31:0]   current_time;
	logic          valid;
	logic [HW-1:0] result_handle;
	logic          expired;
	logic [1:0]    status;
	logic          last;

	// Shadow heap: entries by slot, slot by handle, armed flags and occupancy.
	logic [HW-1:0] q_handle [CAP];
	logic [31:0]   q_key [CAP];
	int unsigned   slot_of [NH];
	bit            armed [NH];
	int unsigned   armed_count = 0;

	timer_result_t pending_results [$];
	int unsigned   error_count = 0;
	int unsigned   cycle_count = 0;
	int unsigned   idle_pct = 0;
	logic [31:0]   sim_now = 32'd0;

	always #5 clk = ~clk;

	min_heap_timer_queue #(
		.CAPACITY  (CAP),
		.TIME_WIDTH(32)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.handle       (handle),
		.expire_time  (expire_time),
		.current_time (current_time),
		.valid        (valid),
		.result_handle(result_handle),
		.expired      (expired),
		.status       (status),
		.last         (last)
	);

	// ---------------------------------------------------------------- shadow heap

	function automatic void heap_place(int unsigned pos, logic [HW-1:0] h,
			logic [31:0] key);
		q_handle[pos] = h;
		q_key[pos]    = key;
		slot_of[h]    = pos;
	endfunction

	// Climb while the parent key is strictly greater; return the final slot.
	function automatic int unsigned heap_rise(int unsigned pos);
		logic [HW-1:0] h;
		logic [31:0]   key;
		int unsigned   par;
		bit            done;
		h    = q_handle[pos];
		key  = q_key[pos];
		done = 1'b0;
		while (pos > 0 && !done) begin
			par = (pos - 1) / 2;
			if (q_key[par] > key) begin
				heap_place(pos, q_handle[par], q_key[par]);
				pos = par;
			end else begin
				done = 1'b1;
			end
		end
		heap_place(pos, h, key);
		return pos;
	endfunction

	// Sink past the smaller child while that child is strictly smaller; the left
	// child wins a tie between children.
	function automatic void heap_sink(int unsigned pos);
		logic [HW-1:0] h;
		logic [31:0]   key;
		int unsigned   c;
		bit            done;
		h    = q_handle[pos];
		key  = q_key[pos];
		done = 1'b0;
		while (!done) begin
			c = 2 * pos + 1;
			if (c >= armed_count) begin
				done = 1'b1;
			end else begin
				if (c + 1 < armed_count && q_key[c] > q_key[c + 1])
					c++;
				if (key > q_key[c]) begin
					heap_place(pos, q_handle[c], q_key[c]);
					pos = c;
				end else begin
					done = 1'b1;
				end
			end
		end
		heap_place(pos, h, key);
	endfunction

	// Disarm the entry at pos, refill the hole from the tail and re-sift both ways.
	function automatic void heap_remove(int unsigned pos);
		armed[q_handle[pos]] = 1'b0;
		armed_count--;
		if (pos != armed_count) begin
			heap_place(pos, q_handle[armed_count], q_key[armed_count]);
			heap_sink(heap_rise(pos));
		end
	endfunction

	// Apply one accepted item to the shadow heap and queue the results it causes.
	function automatic void predict_op(mhtq_pkg::func_t f, logic [HW-1:0] h,
			logic [31:0] et, logic [31:0] ct);
		mhtq_pkg::status_t st;
		timer_result_t     r;
		int                n;
		st = mhtq_pkg::ST_OK;
		if (f == mhtq_pkg::FN_TICK) begin
			// Pop every due entry, earliest first; hold the newest one back so
			// the final one can be flagged as last.
			n = 0;
			while (armed_count > 0 && n < mhtq_pkg::MAX_OUT && q_key[0] <= ct) begin
				if (n > 0)
					pending_results.push_back(r);
				r.hnd   = q_handle[0];
				r.fired = 1'b1;
				r.st    = mhtq_pkg::ST_OK;
				r.lst   = 1'b0;
				n++;
				heap_remove(0);
			end
			if (n > 0) begin
				r.lst = 1'b1;
				pending_results.push_back(r);
			end
		end else begin
			if (f == mhtq_pkg::FN_ADD) begin
				if (armed[h]) begin
					st = mhtq_pkg::ST_DUP;
				end else if (armed_count >= CAP) begin
					st = mhtq_pkg::ST_FULL;
				end else begin
					armed[h] = 1'b1;
					armed_count++;
					heap_place(armed_count - 1, h, et);
					void'(heap_rise(armed_count - 1));
				end
			end else if (!armed[h] || slot_of[h] >= armed_count) begin
				st = mhtq_pkg::ST_ABSENT;
			end else if (f == mhtq_pkg::FN_DEL) begin
				heap_remove(slot_of[h]);
			end else begin
				q_key[slot_of[h]] = et;
				heap_sink(heap_rise(slot_of[h]));
			end
			r.hnd   = h;
			r.fired = 1'b0;
			r.st    = st;
			r.lst   = 1'b1;
			pending_results.push_back(r);
		end
	endfunction

	// Random handle that is (or is not) armed; -1 when there is none.
	function automatic int pick_handle(bit want_armed);
		int base;
		base = $urandom_range(NH - 1);
		for (int i = 0; i < NH; i++)
			if (armed[(base + i) % NH] == want_armed)
				return (base + i) % NH;
		return -1;
	endfunction

	// Expiry mostly a little ahead of the running time, on a coarse grid so that
	// equal keys are common; now and then stale, arbitrary, zero or all ones.
	function automatic logic [31:0] next_key();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 70)
			return sim_now + 32'($urandom_range(0, 20) * 10);
		if (r < 80)
			return sim_now - 32'($urandom_range(0, 50));
		if (r < 88)
			return $urandom;
		if (r < 94)
			return 32'h0000_0000;
		return 32'hFFFF_FFFF;
	endfunction

	// ---------------------------------------------------------------- driving

	// Drive one item at the falling edge and hold it until an edge with busy low
	// takes it. Start stays high on exit so back-to-back items never drop it.
	task automatic send_op(mhtq_pkg::func_t f, logic [HW-1:0] h, logic [31:0] et,
			logic [31:0] ct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start        <= 1'b1;
		func         <= f;
		handle       <= h;
		expire_time  <= et;
		current_time <= ct;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_op(f, h, et, ct);
		@(negedge clk);
	endtask

	// ---------------------------------------------------------------- checking

	task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
		error_count++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
	endtask

	// Results cannot be held off: take each strobe and match it to the oldest
	// expectation, field by field.
	always @(posedge clk) begin : check_result
		timer_result_t want;
		if (arst_n && valid) begin
			if (pending_results.size() == 0) begin
				error_count++;
				$display("%0t: unexpected result, expected none, actual handle %0d %s %0d last %0b",
					$time, result_handle, "expired", expired, last);
			end else begin
				want = pending_results.pop_front();
				if (result_handle !== want.hnd)
					report_field("result_handle", 32'(want.hnd), 32'(result_handle));
				if (expired !== want.fired)
					report_field("expired", 32'(want.fired), 32'(expired));
				if (status !== want.st)
					report_field("status", 32'(want.st), 32'(status));
				if (last !== want.lst)
					report_field("last", 32'(want.lst), 32'(last));
			end
		end
	end

	// Watchdog: a hung handshake ends the run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ---------------------------------------------------------------- tests

	// Field extremes, every operation, rejects, ties and sifting both ways.
	task automatic test_directed();
		send_op(mhtq_pkg::FN_ADD,  6'd0,  32'h0000_0000, 32'hFFFF_FFFF);
		send_op(mhtq_pkg::FN_ADD,  6'd63, 32'hFFFF_FFFF, 32'h0000_0000);
		// duplicate add, then delete and adjust of a handle never armed
		send_op(mhtq_pkg::FN_ADD,  6'd0,  32'd5, 32'd0);
		send_op(mhtq_pkg::FN_DEL,  6'd5,  32'd0, 32'd0);
		send_op(mhtq_pkg::FN_ADJ,  6'd5,  32'd9, 32'd0);
		// pop exactly the zero key, then a tick with nothing due
		send_op(mhtq_pkg::FN_TICK, 6'd63, 32'hFFFF_FFFF, 32'h0000_0000);
		send_op(mhtq_pkg::FN_TICK, 6'd0,  32'h0000_0000, 32'hFFFF_FFFE);
		send_op(mhtq_pkg::FN_ADJ,  6'd63, 32'd100, 32'hFFFF_FFFF);
		send_op(mhtq_pkg::FN_TICK, 6'd21, 32'd0, 32'd99);
		// equal expiries; move only past strictly greater keys
		send_op(mhtq_pkg::FN_ADD,  6'd42, 32'd100, 32'd0);
		send_op(mhtq_pkg::FN_ADD,  6'd21, 32'd100, 32'd0);
		send_op(mhtq_pkg::FN_ADD,  6'd1,  32'd50, 32'd0);
		send_op(mhtq_pkg::FN_DEL,  6'd42, 32'd0, 32'd0);
		send_op(mhtq_pkg::FN_ADD,  6'd42, 32'd100, 32'd0);
		// adjust that climbs to the root, then one that sinks
		send_op(mhtq_pkg::FN_ADJ,  6'd21, 32'd0, 32'd0);
		send_op(mhtq_pkg::FN_ADJ,  6'd1,  32'd200, 32'd0);
		send_op(mhtq_pkg::FN_TICK, 6'd0,  32'd0, 32'd100);
		send_op(mhtq_pkg::FN_TICK, 6'd0,  32'd0, 32'hFFFF_FFFF);
		send_op(mhtq_pkg::FN_DEL,  6'd1,  32'd0, 32'd0);
	endtask

	// Arm every handle, reject one more add, then drain in two ticks, the
	// second popping what is left at once.
	task automatic test_fill_drain();
		int unsigned mask;
		logic [31:0] key;
		mask = $urandom_range(63);
		for (int i = 0; i < NH; i++) begin
			key = $urandom_range(1) ? 32'($urandom_range(0, 15)) : 32'($urandom);
			send_op(mhtq_pkg::FN_ADD, HW'(32'(i) ^ mask), key, $urandom);
		end
		send_op(mhtq_pkg::FN_ADD, HW'($urandom_range(63)), $urandom, $urandom);
		send_op(mhtq_pkg::FN_ADJ, HW'(mask), 32'd3, $urandom);
		send_op(mhtq_pkg::FN_DEL, HW'(mask ^ 1), $urandom, $urandom);
		send_op(mhtq_pkg::FN_ADD, HW'(mask ^ 1), 32'd7, $urandom);
		send_op(mhtq_pkg::FN_TICK, HW'($urandom_range(63)), $urandom, 32'd8);
		send_op(mhtq_pkg::FN_TICK, HW'($urandom_range(63)), $urandom, 32'hFFFF_FFFF);
	endtask

	// Mostly well-formed traffic against a running clock, with some noise.
	task automatic test_random(int unsigned n_items, int unsigned gap_pct);
		int          h;
		int unsigned pick;
		idle_pct = gap_pct;
		sim_now  = $urandom;
		for (int unsigned i = 0; i < n_items; i++) begin
			pick = $urandom_range(99);
			if (pick < 6) begin
				// noise: any operation on any handle and time
				send_op(mhtq_pkg::func_t'(2'($urandom_range(3))), HW'($urandom_range(63)),
					$urandom, $urandom);
			end else if (pick < 46 || armed_count < 4) begin
				h = pick_handle(1'b0);
				if (h < 0)
					h = $urandom_range(63);
				send_op(mhtq_pkg::FN_ADD, HW'(h), next_key(), $urandom);
			end else if (pick < 60) begin
				send_op(mhtq_pkg::FN_DEL, HW'(pick_handle(1'b1)), $urandom, $urandom);
			end else if (pick < 78) begin
				send_op(mhtq_pkg::FN_ADJ, HW'(pick_handle(1'b1)), next_key(), $urandom);
			end else begin
				// advance time; rarely tick at an arbitrary moment
				sim_now += $urandom_range(0, 80);
				send_op(mhtq_pkg::FN_TICK, HW'($urandom_range(63)), $urandom,
					(pick < 81) ? 32'($urandom) : sim_now);
			end
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		func         = mhtq_pkg::FN_ADD;
		handle       = '0;
		expire_time  = '0;
		current_time = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// sender idles about a quarter of the time first, then over half, then never
		idle_pct = 26;
		test_directed();
		test_fill_drain();
		test_random(130, 26);
		test_random(130, 59);
		test_random(130, 0);
		start <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
